// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pbce_pkg.sv
// Package with the types and constants of the packed binary cross erosion block.
package pbce_pkg;

   localparam int MaxRowBytes  = 512;
   localparam int AddrWidth    = $clog2(MaxRowBytes);
   localparam int WidthBits    = 13;
   localparam int HeightBits   = 16;
   localparam int CsrDataWidth = 16;

   localparam logic [WidthBits-1:0]  WidthReset  = WidthBits'(640);
   localparam logic [HeightBits-1:0] HeightReset = HeightBits'(480);
   localparam logic [WidthBits-1:0]  MinWidth    = WidthBits'(9);
   localparam logic [WidthBits-1:0]  MaxWidth    = WidthBits'(8 * MaxRowBytes);

   // Command codes of the request transaction.
   localparam logic CmdPixel = 1'b0;
   localparam logic CmdDrain = 1'b1;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] pixel_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
   } rsp_payload_type;

   // What the front end hands to the compute stage for one transaction.
   typedef struct packed {
      logic       has_result;
      logic       is_drain;
      logic       frame_last;
      logic       y_ge2;
      logic       x_first;
      logic       x_last;
      logic       parity;
      logic [2:0] last_bit;
      logic [7:0] pixel_byte;
   } issue_type;

   // Row buffer access for one cycle; both buffers share the read addresses.
   typedef struct packed {
      logic                 rd_en;
      logic [AddrWidth-1:0] rd_addr0;
      logic [AddrWidth-1:0] rd_addr1;
      logic                 wr_en_a;
      logic                 wr_en_b;
      logic [AddrWidth-1:0] wr_addr;
      logic [7:0]           wr_data;
   } mem_ctl_type;

endpackage

// File: hdl/pbce_ram.sv
// Row buffer memory: one write port and two registered read ports.
module pbce_ram (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [pbce_pkg::AddrWidth-1:0] rd_addr0,
   input  logic [pbce_pkg::AddrWidth-1:0] rd_addr1,
   input  logic                           wr_en,
   input  logic [pbce_pkg::AddrWidth-1:0] wr_addr,
   input  logic [7:0]                     wr_data,
   output logic [7:0]                     rd_data0,
   output logic [7:0]                     rd_data1
);

   logic [7:0] mem_ff [pbce_pkg::MaxRowBytes];
   logic [7:0] rd_data0_ff;
   logic [7:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Reads return the contents before a write to the same entry in this cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= mem_ff[rd_addr0];
         rd_data1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// File: hdl/pbce_ctrl.sv
// Front end: configuration registers, raster counters and row buffer addressing.
module pbce_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [0:0]                        csr_index,
   input  logic [pbce_pkg::CsrDataWidth-1:0] csr_wdata,
   input  logic                              accept,
   input  pbce_pkg::req_payload_type         req_data,
   output pbce_pkg::issue_type               issue,
   output pbce_pkg::mem_ctl_type             mem_ctl
);

   localparam int AW = pbce_pkg::AddrWidth;
   localparam int WB = pbce_pkg::WidthBits;
   localparam int HB = pbce_pkg::HeightBits;

   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic [AW-1:0] col_ff, col_in;
   logic [HB-1:0] row_ff, row_in;
   logic [AW-1:0] drain_ff, drain_in;
   logic          done_ff, done_in;

   logic [WB-1:0] wsat;
   logic [WB-1:0] wm1;
   logic [AW-1:0] w0_last;
   logic [2:0]    last_bit;
   logic [HB-1:0] h_last;
   logic          wr_en;

   // Saturated geometry: index of the last byte of a row and its last pixel bit.
   always_comb begin
      wsat = width_ff;
      if (width_ff < pbce_pkg::MinWidth) begin
         wsat = pbce_pkg::MinWidth;
      end else if (width_ff > pbce_pkg::MaxWidth) begin
         wsat = pbce_pkg::MaxWidth;
      end
      wm1      = wsat - WB'(1);
      w0_last  = wm1[AW+2:3];
      last_bit = ~wm1[2:0];
      h_last   = (height_ff < HB'(2)) ? HB'(1) : height_ff - HB'(1);
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      drain_in  = drain_ff;
      done_in   = done_ff;
      wr_en     = 1'b0;
      issue     = '0;
      if (csr_write_en) begin
         case (pbce_pkg::csr_index_type'(csr_index))
            pbce_pkg::CSR_WIDTH:  width_in  = csr_wdata[WB-1:0];
            pbce_pkg::CSR_HEIGHT: height_in = csr_wdata[HB-1:0];
            default:              width_in  = width_ff;
         endcase
         col_in   = '0;
         row_in   = '0;
         drain_in = '0;
         done_in  = 1'b0;
      end else if (accept) begin
         if (req_data.cmd == pbce_pkg::CmdDrain) begin
            if (done_ff) begin
               issue.has_result = 1'b1;
               issue.is_drain   = 1'b1;
               issue.frame_last = (drain_ff >= w0_last);
               if (drain_ff >= w0_last) begin
                  col_in   = '0;
                  row_in   = '0;
                  drain_in = '0;
                  done_in  = 1'b0;
               end else begin
                  drain_in = drain_ff + AW'(1);
               end
            end
         end else if (!done_ff) begin
            issue.has_result = (row_ff != '0);
            issue.y_ge2      = (row_ff >= HB'(2));
            issue.x_first    = (col_ff == '0);
            issue.x_last     = (col_ff >= w0_last);
            issue.parity     = row_ff[0];
            issue.last_bit   = last_bit;
            issue.pixel_byte = req_data.pixel_byte;
            wr_en            = 1'b1;
            if (col_ff >= w0_last) begin
               col_in = '0;
               if (row_ff >= h_last) begin
                  row_in  = '0;
                  done_in = 1'b1;
               end else begin
                  row_in = row_ff + HB'(1);
               end
            end else begin
               col_in = col_ff + AW'(1);
            end
         end
      end
   end

   // The buffer of the current row parity holds row y-2; it is read and overwritten.
   always_comb begin
      mem_ctl.rd_en    = accept;
      mem_ctl.rd_addr0 = col_ff;
      mem_ctl.rd_addr1 = col_ff + AW'(1);
      mem_ctl.wr_en_a  = wr_en && !row_ff[0];
      mem_ctl.wr_en_b  = wr_en && row_ff[0];
      mem_ctl.wr_addr  = col_ff;
      mem_ctl.wr_data  = req_data.pixel_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pbce_pkg::WidthReset;
         height_ff <= pbce_pkg::HeightReset;
         col_ff    <= '0;
         row_ff    <= '0;
         drain_ff  <= '0;
         done_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         drain_ff  <= drain_in;
         done_ff   <= done_in;
      end
   end

endmodule

// File: hdl/pbce_datapath.sv
// Compute stage and output register: combines the read bytes into the eroded byte.
module pbce_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  pbce_pkg::issue_type       issue,
   input  logic [7:0]                a_rd0,
   input  logic [7:0]                a_rd1,
   input  logic [7:0]                b_rd0,
   input  logic [7:0]                b_rd1,
   output logic                      stage_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pbce_pkg::rsp_payload_type rsp_data
);

   logic                      s2_valid_ff, s2_valid_in;
   pbce_pkg::issue_type       s2_ff;
   logic                      left_ff;
   logic                      out_valid_ff, out_valid_in;
   pbce_pkg::rsp_payload_type out_ff;

   logic       s2_advance;
   logic [7:0] cur_c;
   logic [7:0] prev_c;
   logic [7:0] prev_r;
   logic [7:0] p;

   assign s2_advance  = s2_valid_ff && (!out_valid_ff || rsp_ready);
   assign stage_ready = !s2_valid_ff || s2_advance;

   always_comb begin
      cur_c  = s2_ff.parity ? b_rd0 : a_rd0;
      prev_c = s2_ff.parity ? a_rd0 : b_rd0;
      prev_r = s2_ff.parity ? a_rd1 : b_rd1;
      p = prev_c & {prev_c[6:0], 1'b1} & {1'b1, prev_c[7:1]} & cur_c & s2_ff.pixel_byte;
      if (s2_ff.x_first || !left_ff) begin
         p[7] = 1'b0;
      end
      if (!s2_ff.x_last) begin
         if (!prev_r[7]) begin
            p[0] = 1'b0;
         end
      end else begin
         p[s2_ff.last_bit] = 1'b0;
      end
      if (!s2_ff.y_ge2 || s2_ff.is_drain) begin
         p = '0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (accept) begin
         s2_valid_in = issue.has_result;
      end else if (s2_advance) begin
         s2_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s2_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_ff <= issue;
      end
      if (s2_advance) begin
         out_ff.out_byte   <= p;
         out_ff.frame_last <= s2_ff.frame_last;
         if (!s2_ff.is_drain) begin
            left_ff <= prev_c[0];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: hdl/packed_binary_cross_erosion_top.sv
// Top level of the packed binary cross erosion block.
//
//   port group | direction | handshake             | transaction content
//   req_       | in        | req_valid / req_ready | cmd, pixel_byte
//   rsp_       | out       | rsp_valid / rsp_ready | out_byte, frame_last
//   csr_       | in        | csr_write_en          | csr_index, csr_wdata
//
// One req transaction can be accepted in every clock cycle. The edge that accepts a
// transaction also registers it into the compute stage and starts the synchronous row
// buffer read; the compute stage loads the output register, which drives rsp_valid, once
// that register is empty or being taken. Reset is synchronous and clears the counters and
// sets the width to 640 and the height to 480; the row buffers are not cleared and need no
// clearing pass. When rsp is stalled, the compute stage and then req_ready back up.
//
// The two row buffers alternate between even and odd rows. For an input byte at row y,
// column x, the buffer of the current parity still holds row y-2 at x: it is read and
// overwritten in the same cycle. The other buffer holds row y-1 and is read at x and x+1.
// Bit 0 of the row y-1 byte at x-1 is carried over from the previous transaction.
module packed_binary_cross_erosion_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pbce_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pbce_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_write_en,
   input  logic [0:0]                        csr_index,
   input  logic [pbce_pkg::CsrDataWidth-1:0] csr_wdata
);

   logic                  accept;
   logic                  stage_ready;
   pbce_pkg::issue_type   issue;
   pbce_pkg::mem_ctl_type mem_ctl;
   logic [7:0]            a_rd0;
   logic [7:0]            a_rd1;
   logic [7:0]            b_rd0;
   logic [7:0]            b_rd1;

   // A transaction is taken whenever the compute stage can move on or is empty.
   assign req_ready = stage_ready;
   assign accept    = req_valid && stage_ready;

   pbce_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .req_data     (req_data),
      .issue        (issue),
      .mem_ctl      (mem_ctl)
   );

   // Buffer A holds even rows.
   pbce_ram u_ram_a (
      .clock    (clock),
      .rd_en    (mem_ctl.rd_en),
      .rd_addr0 (mem_ctl.rd_addr0),
      .rd_addr1 (mem_ctl.rd_addr1),
      .wr_en    (mem_ctl.wr_en_a),
      .wr_addr  (mem_ctl.wr_addr),
      .wr_data  (mem_ctl.wr_data),
      .rd_data0 (a_rd0),
      .rd_data1 (a_rd1)
   );

   // Buffer B holds odd rows.
   pbce_ram u_ram_b (
      .clock    (clock),
      .rd_en    (mem_ctl.rd_en),
      .rd_addr0 (mem_ctl.rd_addr0),
      .rd_addr1 (mem_ctl.rd_addr1),
      .wr_en    (mem_ctl.wr_en_b),
      .wr_addr  (mem_ctl.wr_addr),
      .wr_data  (mem_ctl.wr_data),
      .rd_data0 (b_rd0),
      .rd_data1 (b_rd1)
   );

   pbce_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .issue       (issue),
      .a_rd0       (a_rd0),
      .a_rd1       (a_rd1),
      .b_rd0       (b_rd0),
      .b_rd1       (b_rd1),
      .stage_ready (stage_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// File: hdl/pbce_checker.sv
// Port-level checker for the packed binary cross erosion top level, with its bind.
`include "assert_macros.svh"

module pbce_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input pbce_pkg::rsp_payload_type rsp_data
);

   logic rsp_stall;
   logic last_nonzero;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign last_nonzero = rsp_valid && rsp_data.frame_last && (rsp_data.out_byte != 8'h00);

   // No result is pending in the cycle after reset.
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid high after reset")

   // The frame end transaction always belongs to the all-zero last row.
   `ASSERT_CLK_RST(a_last_zero, clock, reset, !last_nonzero, "frame end byte not zero")

   // A stalled result holds its value.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp moved")

endmodule

bind packed_binary_cross_erosion_top pbce_checker u_pbce_checker (.*);

// File: bench/pbce_erosion_checker.sv
// Checker that predicts and compares the eroded bytes of the packed binary cross erosion block.
module pbce_erosion_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  pbce_pkg::req_payload_type         req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  pbce_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_write_en,
   input  logic [0:0]                        csr_index,
   input  logic [pbce_pkg::CsrDataWidth-1:0] csr_wdata,
   output int unsigned                       mismatch_count,
   output int unsigned                       results_pending
);

   logic [7:0]                      even_rows [pbce_pkg::MaxRowBytes];
   logic [7:0]                      odd_rows  [pbce_pkg::MaxRowBytes];
   logic [pbce_pkg::WidthBits-1:0]  width_setting;
   logic [pbce_pkg::HeightBits-1:0] height_setting;
   int unsigned                     column;
   int unsigned                     row;
   int unsigned                     drain_column;
   bit                              frame_complete;
   pbce_pkg::rsp_payload_type       eroded_q [$];

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
   end

   function automatic logic [7:0] erode_within_byte(input logic [7:0] c);
      return c & {c[6:0], 1'b1} & {1'b1, c[7:1]};
   endfunction

   function automatic int unsigned effective_width();
      if (width_setting < pbce_pkg::MinWidth) return pbce_pkg::MinWidth;
      if (width_setting > pbce_pkg::MaxWidth) return pbce_pkg::MaxWidth;
      return width_setting;
   endfunction

   function automatic int unsigned effective_height();
      return (height_setting < 2) ? 2 : height_setting;
   endfunction

   function automatic logic [7:0] stored_byte(input bit odd, input int unsigned x);
      return odd ? odd_rows[x] : even_rows[x];
   endfunction

   function automatic void restart_frame();
      column         = 0;
      row            = 0;
      drain_column   = 0;
      frame_complete = 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // The byte at row y, column x completes the 3x3 cross around row y-1, column x.
   task automatic predict_eroded(input pbce_pkg::req_payload_type item);
      int unsigned               bytes;
      int unsigned               x;
      int unsigned               valid_bits;
      bit                        odd;
      logic [7:0]                centre;
      logic [7:0]                left_byte;
      logic [7:0]                right_byte;
      pbce_pkg::rsp_payload_type result;
      bytes = (effective_width() + 7) / 8;
      if (item.cmd == pbce_pkg::CmdDrain) begin
         if (!frame_complete) return;
         result.out_byte   = 8'h00;
         result.frame_last = (drain_column + 1 >= bytes);
         if (result.frame_last) restart_frame();
         else drain_column++;
         eroded_q.push_back(result);
         return;
      end
      if (frame_complete) return;
      x   = column;
      odd = row[0];
      if (row >= 1) begin
         result.out_byte   = 8'h00;
         result.frame_last = 1'b0;
         if (row >= 2) begin
            // Same parity buffer still holds row y-2; the other one holds row y-1.
            centre = stored_byte(!odd, x);
            result.out_byte = erode_within_byte(centre) & stored_byte(odd, x)
                              & item.pixel_byte;
            left_byte = (x == 0) ? 8'h00 : stored_byte(!odd, x - 1);
            if (!left_byte[0]) result.out_byte[7] = 1'b0;
            if (x + 1 < bytes) begin
               right_byte = stored_byte(!odd, x + 1);
               if (!right_byte[7]) result.out_byte[0] = 1'b0;
            end else begin
               valid_bits = effective_width() - 8 * (bytes - 1);
               result.out_byte[8 - valid_bits] = 1'b0;
            end
         end
         eroded_q.push_back(result);
      end
      if (odd) odd_rows[x] = item.pixel_byte;
      else even_rows[x] = item.pixel_byte;
      if (x + 1 >= bytes) begin
         column = 0;
         if (row + 1 >= effective_height()) begin
            row            = 0;
            frame_complete = 1'b1;
         end else begin
            row++;
         end
      end else begin
         column++;
      end
   endtask

   task automatic check_result(input pbce_pkg::rsp_payload_type seen);
      pbce_pkg::rsp_payload_type wanted;
      if (eroded_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result out_byte %02h frame_last %0d",
                                   seen.out_byte, seen.frame_last));
         return;
      end
      wanted = eroded_q.pop_front();
      if (seen.out_byte !== wanted.out_byte)
         report_mismatch($sformatf("out_byte %02h, expected %02h",
                                   seen.out_byte, wanted.out_byte));
      if (seen.frame_last !== wanted.frame_last)
         report_mismatch($sformatf("frame_last %0d, expected %0d",
                                   seen.frame_last, wanted.frame_last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_setting  = pbce_pkg::WidthReset;
         height_setting = pbce_pkg::HeightReset;
         restart_frame();
         eroded_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == pbce_pkg::CSR_WIDTH)
               width_setting = csr_wdata[pbce_pkg::WidthBits-1:0];
            else height_setting = csr_wdata[pbce_pkg::HeightBits-1:0];
            restart_frame();
         end
         if (req_valid && req_ready) predict_eroded(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
      results_pending = eroded_q.size();
   end

endmodule

// File: bench/tb_packed_binary_cross_erosion_top.sv
// Testbench top of the packed binary cross erosion block: stimulus, pacing and verdict.
module tb_packed_binary_cross_erosion_top;

   localparam int          WidthBits    = pbce_pkg::WidthBits;
   localparam int          HeightBits   = pbce_pkg::HeightBits;
   // Transactions that the whole run aims for, directed frames included.
   localparam int unsigned ItemTarget   = 1250;
   // Pause that lets the block's answer to a transaction arrive, with margin.
   localparam int unsigned SettleCycles = 8;
   // Limit on a quiet stretch; correct gaps, stalls and settle pauses stay well below it.
   localparam int unsigned StallLimit   = 1000;
   // Three rows of 24 pixels; the middle row has a cleared pixel on each side of a byte edge.
   localparam logic [71:0] EdgeRows     = 72'hffffff_fe7fff_ffffff;

   logic                              clock        = 1'b0;
   logic                              reset        = 1'b1;
   logic                              req_valid    = 1'b0;
   logic                              req_ready;
   pbce_pkg::req_payload_type         req_data     = '0;
   logic                              rsp_valid;
   logic                              rsp_ready    = 1'b0;
   pbce_pkg::rsp_payload_type         rsp_data;
   logic                              csr_write_en = 1'b0;
   logic [0:0]                        csr_index    = pbce_pkg::CSR_WIDTH;
   logic [pbce_pkg::CsrDataWidth-1:0] csr_wdata    = '0;
   int unsigned                       mismatch_count;
   int unsigned                       results_pending;

   // Geometry that the stimulus believes the block holds; used only to shape frames.
   logic [WidthBits-1:0]              width_now    = pbce_pkg::WidthReset;
   logic [HeightBits-1:0]             height_now   = pbce_pkg::HeightReset;
   // When set, the matching side never idles, so back-to-back streams are exercised too.
   bit                                req_calm     = 1'b0;
   bit                                rsp_calm     = 1'b0;
   // Transactions that the block acts on; ignored ones are not counted.
   int unsigned                       useful_items = 0;
   int unsigned                       idle_cycles  = 0;

   always #1 clock = ~clock;

   packed_binary_cross_erosion_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pbce_erosion_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // Watchdog: any accepted transaction or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Row bytes as the block derives them from the width register, saturation included.
   function automatic int unsigned bytes_per_row();
      int unsigned w;
      w = width_now;
      if (w < pbce_pkg::MinWidth) w = pbce_pkg::MinWidth;
      if (w > pbce_pkg::MaxWidth) w = pbce_pkg::MaxWidth;
      return (w + 7) / 8;
   endfunction

   function automatic int unsigned rows_per_frame();
      return (height_now < 2) ? 2 : height_now;
   endfunction

   // Mostly dense bytes, so that results survive the five-way AND and carry ones.
   function automatic logic [7:0] pick_pixels();
      case ($urandom_range(0, 9))
         0: begin
            return 8'hff;
         end
         1: begin
            return 8'h00;
         end
         2, 3, 4: begin
            return 8'($urandom);
         end
         default: begin
            return ~(8'($urandom) & 8'($urandom) & 8'($urandom));
         end
      endcase
   endfunction

   function automatic int unsigned pick_width();
      case ($urandom_range(0, 9))
         0: begin
            return $urandom_range(0, 8);
         end
         1: begin
            return $urandom_range(65, 160);
         end
         default: begin
            return $urandom_range(9, 48);
         end
      endcase
   endfunction

   function automatic int unsigned pick_height();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1);
      return $urandom_range(2, 5);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction is accepted,
   // with req_valid still high so that a following transaction can go out back to back.
   task automatic send_item(input logic cmd, input logic [7:0] pixels);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: cmd, pixel_byte: pixels};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Sends pixel bytes in raster order. Noisy mode slips in drains before the frame is
   // complete; the block has to ignore them.
   task automatic send_bytes(input int unsigned count, input bit solid, input bit noisy);
      int unsigned n;
      for (n = 0; n < count; n++) begin
         if (noisy && $urandom_range(0, 39) == 0) send_item(pbce_pkg::CmdDrain, 8'($urandom));
         send_item(pbce_pkg::CmdPixel, solid ? 8'hff : pick_pixels());
         useful_items++;
      end
   endtask

   // Ends a complete frame. Noisy mode may first send a surplus pixel byte, which is ignored.
   task automatic drain_frame(input bit noisy);
      int unsigned n;
      if (noisy && $urandom_range(0, 3) == 0) send_item(pbce_pkg::CmdPixel, pick_pixels());
      for (n = 0; n < bytes_per_row(); n++) begin
         send_item(pbce_pkg::CmdDrain, 8'($urandom));
         useful_items++;
      end
   endtask

   // Writes both registers while the block is idle. Every write restarts the frame.
   // Unused upper bits of the width word are randomized; the block must drop them.
   task automatic configure(input int unsigned width_px, input int unsigned height_px);
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      // Row 0 transactions give no result and may still be in flight here.
      repeat (SettleCycles) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= pbce_pkg::CSR_WIDTH;
      csr_wdata    <= {3'($urandom), WidthBits'(width_px)};
      @(negedge clock);
      csr_index    <= pbce_pkg::CSR_HEIGHT;
      csr_wdata    <= HeightBits'(height_px);
      @(negedge clock);
      csr_write_en <= 1'b0;
      width_now    = WidthBits'(width_px);
      height_now   = HeightBits'(height_px);
   endtask

   // Result side: a random stall before each transaction, with calm stretches in between.
   initial begin
      int unsigned stall;
      @(negedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid || reset);
         @(negedge clock);
         if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
      end
   end

   initial begin
      int unsigned n;
      bit          restart_needed;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Three rows at the reset geometry: the right edge of a 640 pixel row is checked
      // before any register write. The frame is abandoned by the next write.
      send_bytes(3 * bytes_per_row(), 1'b0, 1'b0);

      // Narrowest image: an early drain, two solid rows (row 1 gives an all-zero row),
      // a surplus pixel after the frame, then the drains that close it.
      configure(9, 2);
      send_item(pbce_pkg::CmdDrain, 8'h5a);
      send_bytes(2 * bytes_per_row(), 1'b1, 1'b0);
      send_item(pbce_pkg::CmdPixel, 8'hff);
      drain_frame(1'b0);

      // Solid image whose width is a byte multiple: left edge and last pixel of the row.
      configure(16, 3);
      send_bytes(3 * bytes_per_row(), 1'b1, 1'b0);
      drain_frame(1'b0);

      // Neighbor bits across byte edges clear the adjacent edge pixels.
      configure(24, 3);
      for (n = 0; n < 9; n++) begin
         send_item(pbce_pkg::CmdPixel, EdgeRows[71 - 8 * n -: 8]);
         useful_items++;
      end
      drain_frame(1'b0);

      // Register extremes: the width saturates to the largest row, so the first results
      // appear only once row 1 starts after the full row 0. The frame is abandoned two
      // bytes into row 1.
      configure(8191, 0);
      send_bytes(bytes_per_row() + 2, 1'b0, 1'b0);

      // Tallest height with a short, abandoned frame.
      configure(200, 65535);
      send_bytes(3 * bytes_per_row(), 1'b0, 1'b1);

      // Random frames: mostly complete ones with random content and some noise, a few
      // broken off partway, and a new geometry every few frames.
      restart_needed = 1'b1;
      while (useful_items < ItemTarget) begin
         if (restart_needed || $urandom_range(0, 2) == 0) configure(pick_width(), pick_height());
         req_calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            send_bytes($urandom_range(1, rows_per_frame() * bytes_per_row() - 1), 1'b0, 1'b1);
            restart_needed = 1'b1;
         end else begin
            send_bytes(rows_per_frame() * bytes_per_row(), 1'b0, 1'b1);
            drain_frame(1'b1);
            restart_needed = 1'b0;
         end
      end

      // Let every expected result arrive, then allow for anything stray.
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
